// ===== src/csc_pkg.sv =====
// shared constants and types for the capsule segment collision pipeline
package csc_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT   = 16;

   // quotients carry this many fraction bits
   localparam int QSHIFT = 32;

   // 1e-5 threshold: x < 1e-5 <=> x * 100000 < one unit
   localparam int EPS_SCALE = 100000;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TEST = 1'b1;

   // unit power of a quantity, counted in frac_bits
   typedef enum logic [2:0] {
      UNIT_ONE  = 3'd0,
      UNIT_SQ   = 3'd2,
      UNIT_QUAD = 3'd4
   } unit_type;

endpackage

// ===== src/capsule_segment_collision.sv =====
// closest points between two 3d segments and capsule overlap test, fully pipelined
//
//  channel  ports                         handshake
//  request  req_mode, req_start_*, ...    word taken when start high and busy low
//  response rsp_ref_point_*, ...          rsp_valid strobe, one cycle, no back pressure
//
// one word enters per cycle; busy is always low
// a test word gives its response after the edge, dot product, divider and tail stages;
//   the two 32-step restoring dividers make up most of that depth
// a load word updates the reference at once and gives no response
// synchronous reset clears the reference and all stage valid bits
module capsule_segment_collision
   import csc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_z,
   input  logic        [COORD_WIDTH-2:0] req_radius,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_ref_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_ref_point_y,
   output logic signed [COORD_WIDTH-1:0] rsp_ref_point_z,
   output logic signed [COORD_WIDTH-1:0] rsp_cand_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_cand_point_y,
   output logic signed [COORD_WIDTH-1:0] rsp_cand_point_z,
   output logic                          rsp_collide
);

   localparam int W    = COORD_WIDTH;
   localparam int DW   = 2 * W + 4;               // dot products
   localparam int HW   = DW / 2;                  // halves of a dot product
   localparam int PW   = 2 * DW;                  // products of dot products
   localparam int NW   = PW + 2;                  // numerators and denominators
   localparam int EW   = NW + 18 + 4 * FRAC_BITS; // threshold test
   localparam int QW   = QSHIFT + 1;              // quotient up to exactly 1.0
   localparam int MW   = W + QW + 2;              // delta times quotient
   localparam int SIDE = 10 + QSHIFT;
   localparam int LATENCY = 14 + QSHIFT;

   typedef struct packed {
      logic [2:0][W-1:0] rs;
      logic [2:0][W-1:0] cs;
      logic [2:0][W:0]   u;
      logic [2:0][W:0]   v;
      logic [W-1:0]      rsum;
   } side_type;

   typedef struct packed {
      logic [NW-1:0]     rem;
      logic [NW-1:0]     den;
      logic [QSHIFT-1:0] q;
      logic              zero;
      logic              one;
   } div_type;

   // partial products of two dot products split into a signed high and unsigned low half
   typedef struct packed {
      logic [2*HW-1:0] hh;
      logic [2*HW:0]   hl;
      logic [2*HW:0]   lh;
      logic [2*HW-1:0] ll;
   } part_type;

   function automatic logic below_eps(input logic signed [NW-1:0] x, input unit_type k);
      logic [NW-1:0] ax;
      logic [EW-1:0] m;
      logic [EW-1:0] thr;
      ax  = x[NW-1] ? NW'(-x) : NW'(x);
      m   = EW'(ax) * EW'(EPS_SCALE);
      thr = EW'(1) << (int'(k) * FRAC_BITS);
      return m < thr;
   endfunction

   function automatic part_type split_mul(input logic signed [DW-1:0] x,
                                          input logic signed [DW-1:0] y);
      part_type p;
      p.hh = $signed(x[DW-1:HW]) * $signed(y[DW-1:HW]);
      p.hl = $signed(x[DW-1:HW]) * $signed({1'b0, y[HW-1:0]});
      p.lh = $signed({1'b0, x[HW-1:0]}) * $signed(y[DW-1:HW]);
      p.ll = x[HW-1:0] * y[HW-1:0];
      return p;
   endfunction

   function automatic logic signed [PW-1:0] join_mul(input part_type p);
      return (PW'($signed(p.hh)) <<< (2 * HW)) + (PW'($signed(p.hl)) <<< HW)
           + (PW'($signed(p.lh)) <<< HW) + PW'(p.ll);
   endfunction

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // reference segment
   logic signed [W-1:0] ref_start_ff [3];
   logic signed [W-1:0] ref_end_ff   [3];
   logic        [W-2:0] ref_radius_ff;

   logic signed [W-1:0] req_s [3];
   logic signed [W-1:0] req_e [3];
   assign req_s = '{req_start_x, req_start_y, req_start_z};
   assign req_e = '{req_end_x, req_end_y, req_end_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ref_start_ff[i] <= '0;
            ref_end_ff[i]   <= '0;
         end
         ref_radius_ff <= '0;
      end else if (accept && req_mode == MODE_LOAD) begin
         for (int i = 0; i < 3; i++) begin
            ref_start_ff[i] <= req_s[i];
            ref_end_ff[i]   <= req_e[i];
         end
         ref_radius_ff <= req_radius;
      end
   end

   // stage 1: edge vectors
   side_type            side_in;
   logic signed [W:0]   w_in [3];
   side_type            side_ff [SIDE];
   logic                side_vld_ff [SIDE];
   logic signed [W:0]   w_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         side_in.rs[i] = ref_start_ff[i];
         side_in.cs[i] = req_s[i];
         side_in.u[i]  = (W+1)'(ref_end_ff[i]) - (W+1)'(ref_start_ff[i]);
         side_in.v[i]  = (W+1)'(req_e[i]) - (W+1)'(req_s[i]);
         w_in[i]       = (W+1)'(ref_start_ff[i]) - (W+1)'(req_s[i]);
      end
      side_in.rsum = {1'b0, ref_radius_ff} + {1'b0, req_radius};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SIDE; k++) side_vld_ff[k] <= 1'b0;
      end else begin
         side_vld_ff[0] <= accept && req_mode == MODE_TEST;
         for (int k = 1; k < SIDE; k++) side_vld_ff[k] <= side_vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int k = 1; k < SIDE; k++) side_ff[k] <= side_ff[k-1];
      w_ff <= w_in;
   end

   // stage 2: dot products
   logic signed [DW-1:0] a_in, b_in, c_in, d_in, e_in;
   logic signed [DW-1:0] a2_ff, b2_ff, c2_ff, d2_ff, e2_ff;

   always_comb begin
      logic signed [DW-1:0] u, v, w;
      a_in = '0; b_in = '0; c_in = '0; d_in = '0; e_in = '0;
      for (int i = 0; i < 3; i++) begin
         u = DW'($signed(side_ff[0].u[i]));
         v = DW'($signed(side_ff[0].v[i]));
         w = DW'(w_ff[i]);
         a_in = a_in + u * u;
         b_in = b_in + u * v;
         c_in = c_in + v * v;
         d_in = d_in + u * w;
         e_in = e_in + v * w;
      end
   end

   always_ff @(posedge clock) begin
      a2_ff <= a_in; b2_ff <= b_in; c2_ff <= c_in; d2_ff <= d_in; e2_ff <= e_in;
   end

   // stage 3: half-width partial products
   part_type             acp_ff, bbp_ff, bep_ff, cdp_ff, aep_ff, bdp_ff;
   logic signed [DW-1:0] ap_ff, bp_ff, cp_ff, dp_ff, ep_ff;

   always_ff @(posedge clock) begin
      acp_ff <= split_mul(a2_ff, c2_ff);
      bbp_ff <= split_mul(b2_ff, b2_ff);
      bep_ff <= split_mul(b2_ff, e2_ff);
      cdp_ff <= split_mul(c2_ff, d2_ff);
      aep_ff <= split_mul(a2_ff, e2_ff);
      bdp_ff <= split_mul(b2_ff, d2_ff);
      ap_ff <= a2_ff; bp_ff <= b2_ff; cp_ff <= c2_ff; dp_ff <= d2_ff; ep_ff <= e2_ff;
   end

   // stage 3b: cross products
   logic signed [PW-1:0] ac3_ff, bb3_ff, be3_ff, cd3_ff, ae3_ff, bd3_ff;
   logic signed [DW-1:0] a3_ff, b3_ff, c3_ff, d3_ff, e3_ff;

   always_ff @(posedge clock) begin
      ac3_ff <= join_mul(acp_ff);
      bb3_ff <= join_mul(bbp_ff);
      be3_ff <= join_mul(bep_ff);
      cd3_ff <= join_mul(cdp_ff);
      ae3_ff <= join_mul(aep_ff);
      bd3_ff <= join_mul(bdp_ff);
      a3_ff <= ap_ff; b3_ff <= bp_ff; c3_ff <= cp_ff; d3_ff <= dp_ff; e3_ff <= ep_ff;
   end

   // stage 4: determinant and raw numerators
   logic signed [NW-1:0] f4_ff, sn4_ff, tn4_ff;
   logic signed [DW-1:0] a4_ff, b4_ff, c4_ff, d4_ff, e4_ff;

   always_ff @(posedge clock) begin
      f4_ff  <= NW'(ac3_ff) - NW'(bb3_ff);
      sn4_ff <= NW'(be3_ff) - NW'(cd3_ff);
      tn4_ff <= NW'(ae3_ff) - NW'(bd3_ff);
      a4_ff <= a3_ff; b4_ff <= b3_ff; c4_ff <= c3_ff; d4_ff <= d3_ff; e4_ff <= e3_ff;
   end

   // stage 5: parallel test and first compares
   logic signed [NW-1:0] f5_ff, sn5_ff, tn5_ff;
   logic signed [DW-1:0] a5_ff, b5_ff, c5_ff, d5_ff, e5_ff;
   logic                 fsmall5_ff, sneg5_ff, sgt5_ff;

   always_ff @(posedge clock) begin
      f5_ff <= f4_ff; sn5_ff <= sn4_ff; tn5_ff <= tn4_ff;
      a5_ff <= a4_ff; b5_ff <= b4_ff; c5_ff <= c4_ff; d5_ff <= d4_ff; e5_ff <= e4_ff;
      fsmall5_ff <= below_eps(f4_ff, UNIT_QUAD);
      sneg5_ff   <= sn4_ff < 0;
      sgt5_ff    <= sn4_ff > f4_ff;
   end

   // stage 6: select the first parameter candidates
   logic signed [NW-1:0] sn6_in, sd6_in, tn6_in, td6_in;
   unit_type             sk6_in, tk6_in;
   logic signed [NW-1:0] sn6_ff, sd6_ff, tn6_ff, td6_ff, nd6_ff, nb6_ff, a6_ff;
   unit_type             sk6_ff, tk6_ff;

   always_comb begin
      if (fsmall5_ff) begin
         sn6_in = '0;  sd6_in = NW'(1);  sk6_in = UNIT_ONE;
         tn6_in = NW'(e5_ff); td6_in = NW'(c5_ff); tk6_in = UNIT_SQ;
      end else begin
         sn6_in = sn5_ff; sd6_in = f5_ff; sk6_in = UNIT_QUAD;
         tn6_in = tn5_ff; td6_in = f5_ff; tk6_in = UNIT_QUAD;
         if (sneg5_ff) begin
            sn6_in = '0;
            tn6_in = NW'(e5_ff); td6_in = NW'(c5_ff); tk6_in = UNIT_SQ;
         end else if (sgt5_ff) begin
            sn6_in = f5_ff;
            tn6_in = NW'(e5_ff) + NW'(b5_ff); td6_in = NW'(c5_ff); tk6_in = UNIT_SQ;
         end
      end
   end

   always_ff @(posedge clock) begin
      sn6_ff <= sn6_in; sd6_ff <= sd6_in; sk6_ff <= sk6_in;
      tn6_ff <= tn6_in; td6_ff <= td6_in; tk6_ff <= tk6_in;
      nd6_ff <= -NW'(d5_ff);
      nb6_ff <= NW'(b5_ff) - NW'(d5_ff);
      a6_ff  <= NW'(a5_ff);
   end

   // stage 7: clamp compares
   logic signed [NW-1:0] sn7_ff, sd7_ff, tn7_ff, td7_ff, nd7_ff, nb7_ff, a7_ff;
   unit_type             sk7_ff, tk7_ff;
   logic                 tneg7_ff, tgt7_ff, ndneg7_ff, ndgt7_ff, nbneg7_ff, nbgt7_ff;

   always_ff @(posedge clock) begin
      sn7_ff <= sn6_ff; sd7_ff <= sd6_ff; sk7_ff <= sk6_ff;
      tn7_ff <= tn6_ff; td7_ff <= td6_ff; tk7_ff <= tk6_ff;
      nd7_ff <= nd6_ff; nb7_ff <= nb6_ff; a7_ff <= a6_ff;
      tneg7_ff  <= tn6_ff < 0;
      tgt7_ff   <= tn6_ff > td6_ff;
      ndneg7_ff <= nd6_ff < 0;
      ndgt7_ff  <= nd6_ff > a6_ff;
      nbneg7_ff <= nb6_ff < 0;
      nbgt7_ff  <= nb6_ff > a6_ff;
   end

   // stage 8: clamp the candidate parameter, recompute the reference one
   logic signed [NW-1:0] sn8_in, sd8_in, tn8_in;
   unit_type             sk8_in;
   logic signed [NW-1:0] sn8_ff, sd8_ff, tn8_ff, td8_ff;
   unit_type             sk8_ff, tk8_ff;

   always_comb begin
      sn8_in = sn7_ff; sd8_in = sd7_ff; sk8_in = sk7_ff; tn8_in = tn7_ff;
      if (tneg7_ff) begin
         tn8_in = '0;
         if (ndneg7_ff) sn8_in = '0;
         else if (ndgt7_ff) sn8_in = sd7_ff;
         else begin
            sn8_in = nd7_ff; sd8_in = a7_ff; sk8_in = UNIT_SQ;
         end
      end else if (tgt7_ff) begin
         tn8_in = td7_ff;
         if (nbneg7_ff) sn8_in = '0;
         else if (nbgt7_ff) sn8_in = sd7_ff;
         else begin
            sn8_in = nb7_ff; sd8_in = a7_ff; sk8_in = UNIT_SQ;
         end
      end
   end

   always_ff @(posedge clock) begin
      sn8_ff <= sn8_in; sd8_ff <= sd8_in; sk8_ff <= sk8_in;
      tn8_ff <= tn8_in; td8_ff <= td7_ff; tk8_ff <= tk7_ff;
   end

   // stage 9: quotient special cases, then restoring division one bit a stage
   div_type sdiv_ff [QSHIFT+1];
   div_type tdiv_ff [QSHIFT+1];

   always_ff @(posedge clock) begin
      sdiv_ff[0].rem  <= sn8_ff;
      sdiv_ff[0].den  <= sd8_ff;
      sdiv_ff[0].q    <= '0;
      sdiv_ff[0].zero <= sd8_ff <= 0 || sn8_ff <= 0 || below_eps(sn8_ff, sk8_ff);
      sdiv_ff[0].one  <= sn8_ff >= sd8_ff;
      tdiv_ff[0].rem  <= tn8_ff;
      tdiv_ff[0].den  <= td8_ff;
      tdiv_ff[0].q    <= '0;
      tdiv_ff[0].zero <= td8_ff <= 0 || tn8_ff <= 0 || below_eps(tn8_ff, tk8_ff);
      tdiv_ff[0].one  <= tn8_ff >= td8_ff;
   end

   for (genvar j = 0; j < QSHIFT; j++) begin : g_div
      logic [NW-1:0] srem2, trem2;
      logic          sge, tge;
      assign srem2 = {sdiv_ff[j].rem[NW-2:0], 1'b0};
      assign trem2 = {tdiv_ff[j].rem[NW-2:0], 1'b0};
      assign sge   = srem2 >= sdiv_ff[j].den;
      assign tge   = trem2 >= tdiv_ff[j].den;
      always_ff @(posedge clock) begin
         sdiv_ff[j+1].rem  <= sge ? srem2 - sdiv_ff[j].den : srem2;
         sdiv_ff[j+1].den  <= sdiv_ff[j].den;
         sdiv_ff[j+1].q    <= {sdiv_ff[j].q[QSHIFT-2:0], sge};
         sdiv_ff[j+1].zero <= sdiv_ff[j].zero;
         sdiv_ff[j+1].one  <= sdiv_ff[j].one;
         tdiv_ff[j+1].rem  <= tge ? trem2 - tdiv_ff[j].den : trem2;
         tdiv_ff[j+1].den  <= tdiv_ff[j].den;
         tdiv_ff[j+1].q    <= {tdiv_ff[j].q[QSHIFT-2:0], tge};
         tdiv_ff[j+1].zero <= tdiv_ff[j].zero;
         tdiv_ff[j+1].one  <= tdiv_ff[j].one;
      end
   end

   // tail: scale deltas, saturate points, squared distance, compare
   logic [QW-1:0]         sc, tc;
   logic signed [MW-1:0]  pm_ff [3];
   logic signed [MW-1:0]  qm_ff [3];
   logic signed [W-1:0]   rs_ff [3];
   logic signed [W-1:0]   cs_ff [3];
   logic [W-1:0]          rsum42_ff, rsum43_ff;
   logic signed [W-1:0]   pt_ff [3];
   logic signed [W-1:0]   qt_ff [3];
   logic [2*W+1:0]        sq_ff [3];
   logic [2*W+1:0]        rr_ff;
   logic signed [W-1:0]   pt44_ff [3];
   logic signed [W-1:0]   qt44_ff [3];
   logic [3:0]            tail_vld_ff;
   logic signed [W-1:0]   pt_in [3];
   logic signed [W-1:0]   qt_in [3];

   assign sc = sdiv_ff[QSHIFT].zero ? '0 :
               sdiv_ff[QSHIFT].one  ? QW'(1) << QSHIFT : {1'b0, sdiv_ff[QSHIFT].q};
   assign tc = tdiv_ff[QSHIFT].zero ? '0 :
               tdiv_ff[QSHIFT].one  ? QW'(1) << QSHIFT : {1'b0, tdiv_ff[QSHIFT].q};

   function automatic logic signed [W-1:0] place(input logic signed [W-1:0] base,
                                                  input logic signed [MW-1:0] pm);
      logic signed [MW-1:0] sum;
      sum = MW'(base) + (pm >>> QSHIFT);
      if (sum[MW-1:W-1] != {(MW-W+1){sum[MW-1]}})
         return sum[MW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      return sum[W-1:0];
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pt_in[i] = place(rs_ff[i], pm_ff[i]);
         qt_in[i] = place(cs_ff[i], qm_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pm_ff[i] <= MW'($signed(side_ff[SIDE-1].u[i])) * MW'($signed({1'b0, sc}));
         qm_ff[i] <= MW'($signed(side_ff[SIDE-1].v[i])) * MW'($signed({1'b0, tc}));
         rs_ff[i] <= side_ff[SIDE-1].rs[i];
         cs_ff[i] <= side_ff[SIDE-1].cs[i];
         pt_ff[i] <= pt_in[i];
         qt_ff[i] <= qt_in[i];
         sq_ff[i] <= (2*W+2)'((W+1)'(pt_ff[i]) - (W+1)'(qt_ff[i]))
                   * (2*W+2)'((W+1)'(pt_ff[i]) - (W+1)'(qt_ff[i]));
         pt44_ff[i] <= pt_ff[i];
         qt44_ff[i] <= qt_ff[i];
      end
      rsum42_ff <= side_ff[SIDE-1].rsum;
      rsum43_ff <= rsum42_ff;
      rr_ff     <= (2*W+2)'(rsum43_ff) * (2*W+2)'(rsum43_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_vld_ff <= '0;
      end else begin
         tail_vld_ff <= {tail_vld_ff[2:0], side_vld_ff[SIDE-1]};
      end
   end

   always_ff @(posedge clock) begin
      rsp_ref_point_x  <= pt44_ff[0];
      rsp_ref_point_y  <= pt44_ff[1];
      rsp_ref_point_z  <= pt44_ff[2];
      rsp_cand_point_x <= qt44_ff[0];
      rsp_cand_point_y <= qt44_ff[1];
      rsp_cand_point_z <= qt44_ff[2];
      // three squares of w+1 bit values stay below 2^(2w+2)
      rsp_collide <= (sq_ff[0] + sq_ff[1] + sq_ff[2]) < rr_ff;
   end

   assign rsp_valid = tail_vld_ff[3];

   // every test word produces a response after the fixed depth
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == MODE_TEST |-> ##LATENCY rsp_valid)
      else $error("test word lost in pipeline");

   // no response without a test word at the matching earlier cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_mode == MODE_TEST, LATENCY))
      else $error("response without a matching test word");

   // load words never reach the response side
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == MODE_LOAD |-> ##LATENCY !rsp_valid)
      else $error("load word produced a response");

endmodule

// ===== tb/csc_checker.sv =====
// checker for capsule_segment_collision: predicts each test word and compares responses
`timescale 1ns / 1ps
module csc_checker
   import csc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_mode,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_end_z,
   input  logic        [30:0] req_radius,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_ref_point_x,
   input  logic signed [31:0] rsp_ref_point_y,
   input  logic signed [31:0] rsp_ref_point_z,
   input  logic signed [31:0] rsp_cand_point_x,
   input  logic signed [31:0] rsp_cand_point_y,
   input  logic signed [31:0] rsp_cand_point_z,
   input  logic               rsp_collide,
   output int                 fail_count,
   output int                 pending
);

   typedef logic signed [255:0] wint_type;
   typedef logic signed [63:0]  coord_type;

   typedef struct {
      coord_type ref_pt [3];
      coord_type cand_pt[3];
      logic      collide;
   } contact_type;

   contact_type contact_q[$];
   coord_type   seg_start[3];
   coord_type   seg_end[3];
   coord_type   seg_radius;

   function automatic logic under_eps(wint_type x, unit_type k, logic magnitude);
      wint_type ax;
      ax = (magnitude && x < 0) ? -x : x;
      return (ax * wint_type'(EPS_SCALE)) < (wint_type'(1) <<< (int'(k) * 16));
   endfunction

   function automatic coord_type param_quot(wint_type n, wint_type dn);
      wint_type q;
      if (dn <= 0 || n <= 0) return 0;
      if (n >= dn) return coord_type'(1) <<< QSHIFT;
      q = (n <<< QSHIFT) / dn;
      return coord_type'(q);
   endfunction

   function automatic coord_type seg_point(coord_type base, coord_type delta, coord_type q);
      wint_type t;
      t = ((wint_type'(delta) * wint_type'(q)) >>> QSHIFT) + wint_type'(base);
      if (t < -(wint_type'(1) <<< 31)) return -(coord_type'(1) <<< 31);
      if (t > (wint_type'(1) <<< 31) - 1) return (coord_type'(1) <<< 31) - 1;
      return coord_type'(t);
   endfunction

   function automatic wint_type dot3(coord_type x[3], coord_type y[3]);
      wint_type r;
      r = 0;
      for (int i = 0; i < 3; i++) r += wint_type'(x[i]) * wint_type'(y[i]);
      return r;
   endfunction

   function automatic contact_type closest_contact(coord_type s[3], coord_type en[3],
                                                   coord_type rad);
      coord_type   u[3], v[3], w[3], sc, tc;
      wint_type    a, b, c, d, e, f, sn, sd, tn, td, nd, nb, dist_sq, rsum;
      unit_type    sk, tk;
      contact_type r;
      for (int i = 0; i < 3; i++) begin
         u[i] = seg_end[i] - seg_start[i];
         v[i] = en[i] - s[i];
         w[i] = seg_start[i] - s[i];
      end
      a = dot3(u, u); b = dot3(u, v); c = dot3(v, v); d = dot3(u, w); e = dot3(v, w);
      f = a * c - b * b;
      if (under_eps(f, UNIT_QUAD, 1'b0)) begin
         sn = 0; sd = 1; sk = UNIT_ONE; tn = e; td = c; tk = UNIT_SQ;
      end else begin
         sn = b * e - c * d; tn = a * e - b * d;
         sd = f; td = f; sk = UNIT_QUAD; tk = UNIT_QUAD;
         if (sn < 0) begin
            sn = 0; tn = e; td = c; tk = UNIT_SQ;
         end else if (sn > sd) begin
            sn = sd; tn = e + b; td = c; tk = UNIT_SQ;
         end
      end
      nd = -d;
      nb = nd + b;
      // clamp t and redo s on the clamped edge
      if (tn < 0) begin
         tn = 0;
         if (nd < 0) sn = 0;
         else if (nd > a) sn = sd;
         else begin
            sn = nd; sd = a; sk = UNIT_SQ;
         end
      end else if (tn > td) begin
         tn = td;
         if (nb < 0) sn = 0;
         else if (nb > a) sn = sd;
         else begin
            sn = nb; sd = a; sk = UNIT_SQ;
         end
      end
      sc = under_eps(sn, sk, 1'b1) ? 0 : param_quot(sn, sd);
      tc = under_eps(tn, tk, 1'b1) ? 0 : param_quot(tn, td);
      dist_sq = 0;
      for (int i = 0; i < 3; i++) begin
         r.ref_pt[i]  = seg_point(seg_start[i], u[i], sc);
         r.cand_pt[i] = seg_point(s[i], v[i], tc);
         dist_sq += wint_type'(r.ref_pt[i] - r.cand_pt[i])
                  * wint_type'(r.ref_pt[i] - r.cand_pt[i]);
      end
      rsum = wint_type'(seg_radius + rad);
      r.collide = dist_sq < rsum * rsum;
      return r;
   endfunction

   task automatic check_field(string name, coord_type exp_v, coord_type act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   assign pending = contact_q.size();

   always @(posedge clock) begin
      coord_type   s[3], en[3];
      contact_type exp_c;
      if (reset) begin
         contact_q.delete();
         fail_count = 0;
         for (int i = 0; i < 3; i++) begin
            seg_start[i] = 0; seg_end[i] = 0;
         end
         seg_radius = 0;
      end else begin
         if (rsp_valid) begin
            if (contact_q.size() == 0) begin
               $error("response with no test word outstanding");
               fail_count++;
            end else begin
               exp_c = contact_q.pop_front();
               check_field("ref_point_x", exp_c.ref_pt[0], coord_type'(rsp_ref_point_x));
               check_field("ref_point_y", exp_c.ref_pt[1], coord_type'(rsp_ref_point_y));
               check_field("ref_point_z", exp_c.ref_pt[2], coord_type'(rsp_ref_point_z));
               check_field("cand_point_x", exp_c.cand_pt[0], coord_type'(rsp_cand_point_x));
               check_field("cand_point_y", exp_c.cand_pt[1], coord_type'(rsp_cand_point_y));
               check_field("cand_point_z", exp_c.cand_pt[2], coord_type'(rsp_cand_point_z));
               check_field("collide", coord_type'(exp_c.collide), coord_type'(rsp_collide));
            end
         end
         if (start && !busy) begin
            s  = '{coord_type'(req_start_x), coord_type'(req_start_y),
                   coord_type'(req_start_z)};
            en = '{coord_type'(req_end_x), coord_type'(req_end_y), coord_type'(req_end_z)};
            if (req_mode == MODE_LOAD) begin
               seg_start = s; seg_end = en; seg_radius = coord_type'(req_radius);
            end else begin
               contact_q.push_back(closest_contact(s, en, coord_type'(req_radius)));
            end
         end
      end
   end

endmodule

// ===== tb/tb.sv =====
// testbench top for capsule_segment_collision: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb;
   import csc_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_mode = MODE_LOAD;
   logic signed [31:0] req_start_x = 0, req_start_y = 0, req_start_z = 0;
   logic signed [31:0] req_end_x = 0, req_end_y = 0, req_end_z = 0;
   logic        [30:0] req_radius = '0;
   logic               rsp_valid, rsp_collide;
   logic signed [31:0] rsp_ref_point_x, rsp_ref_point_y, rsp_ref_point_z;
   logic signed [31:0] rsp_cand_point_x, rsp_cand_point_y, rsp_cand_point_z;
   int                 fail_count, pending;
   int                 quiet_cycles;
   logic signed [31:0] seg_copy[6];

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 60;

   always #4 clock = ~clock;

   capsule_segment_collision dut (.*);

   csc_checker chk (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         2:       return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         3:       return $signed($urandom_range(0, 511)) - 256;
         default: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
      endcase
   endfunction

   function automatic logic [30:0] pick_radius();
      case ($urandom_range(0, 3))
         0:       return 31'($urandom());
         1:       return $urandom_range(0, 1) ? 31'h7fffffff : 31'd0;
         default: return 31'($urandom_range(0, 32'h30000));
      endcase
   endfunction

   // drive one word and hold it until taken
   task automatic send_word(logic mode, logic signed [31:0] c[6], logic [30:0] rad);
      @(negedge clock);
      start = 1'b1; req_mode = mode;
      req_start_x = c[0]; req_start_y = c[1]; req_start_z = c[2];
      req_end_x = c[3]; req_end_y = c[4]; req_end_z = c[5];
      req_radius = rad;
      while (busy) @(negedge clock);
      if (mode == MODE_LOAD) seg_copy = c;
   endtask

   task automatic gap(int n);
      for (int i = 0; i < n; i++) begin
         @(negedge clock);
         start = 1'b0;
         req_mode = 1'($urandom()); req_start_x = $urandom(); req_end_z = $urandom();
         req_radius = 31'($urandom());
      end
   endtask

   task automatic random_word(bit allow_gaps);
      logic signed [31:0] c[6];
      logic signed [31:0] off;
      int                 kind;
      if (allow_gaps && $urandom_range(0, 99) < 17) gap($urandom_range(1, 4));
      kind = $urandom_range(0, 99);
      for (int i = 0; i < 6; i++) c[i] = pick_coord();
      if (kind < 10) begin
         send_word(MODE_LOAD, c, pick_radius());
      end else begin
         if (kind < 25) begin
            // parallel to the reference, shifted
            off = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            for (int i = 0; i < 6; i++) c[i] = seg_copy[i] + off;
         end else if (kind < 32) begin
            // point segment
            for (int i = 0; i < 3; i++) c[3 + i] = c[i];
         end
         send_word(MODE_TEST, c, pick_radius());
      end
   endtask

   initial begin
      logic signed [31:0] c[6];
      int                 waited;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero reference, then extremes, parallel and degenerate shapes
      c = '{0, 0, 0, 0, 0, 0};
      send_word(MODE_TEST, c, 31'd0);
      c = '{0, 0, 0, 32'sh10000, 0, 0};
      send_word(MODE_TEST, c, 31'h7fffffff);
      send_word(MODE_LOAD, '{0, 0, 0, 32'sh40000, 0, 0}, 31'h8000);
      send_word(MODE_TEST, '{0, 32'sh10000, 0, 32'sh40000, 32'sh10000, 0}, 31'h8000);
      send_word(MODE_TEST, '{32'sh10000, -32'sh10000, 0, 32'sh10000, 32'sh10000, 0}, 31'd0);
      send_word(MODE_TEST, '{32'sh50000, 0, 0, 32'sh60000, 0, 0}, 31'h10000);
      send_word(MODE_TEST, '{-32'sh30000, 5, 0, -32'sh20000, 5, 0}, 31'h10);
      send_word(MODE_TEST, '{32'sh20000, 32'sh20000, 0, 32'sh20000, 32'sh20000, 0}, 31'h20000);
      send_word(MODE_TEST, '{32'sh20000, 1, 1, 32'sh20000, 1, 1}, 31'h7fffffff);
      send_word(MODE_LOAD, '{32'sh80000000, 32'sh80000000, 32'sh80000000,
                             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 31'h7fffffff);
      send_word(MODE_TEST, '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                             32'sh80000000, 32'sh7fffffff, 32'sh80000000}, 31'h7fffffff);
      send_word(MODE_TEST, '{32'sh80000000, 32'sh80000000, 32'sh80000000,
                             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 31'd0);
      send_word(MODE_TEST, '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 31'h1);
      send_word(MODE_LOAD, '{3, 3, 3, 3, 3, 3}, 31'd0);
      send_word(MODE_TEST, '{3, 3, 3, 3, 3, 3}, 31'd0);
      send_word(MODE_TEST, '{4, 3, 3, 4, 3, 3}, 31'd1);
      send_word(MODE_TEST, '{-32'sh10000, 3, 3, 32'sh10000, 3, 3}, 31'd0);
      send_word(MODE_LOAD, '{0, 0, 0, 1, 0, 0}, 31'd0);
      send_word(MODE_TEST, '{0, 1, 0, 0, 2, 0}, 31'd0);

      // random, with a long stretch of back-to-back words in the middle
      for (int n = 0; n < 1530; n++) random_word(!(n >= 600 && n < 900));

      @(negedge clock);
      start = 1'b0;
      waited = 0;
      while (pending != 0 && waited < 1000) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
